// ===== rtl/core/dlpg_pkg.sv =====
// ----------------------------------------------------------------------------
// dlpg_pkg
// shared types and constants of the dda line point generator
// ----------------------------------------------------------------------------
package dlpg_pkg;

    localparam int C_COORD_BITS  = 6;
    localparam int C_QUEUE_DEPTH = 2;

    typedef logic [C_COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_line_in;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   last_point;
    } t_point_out;

    // classified line, as passed from the front to the back
    typedef struct packed {
        logic   major_is_x;
        logic   step_backward;
        t_coord major_start;
        t_coord major_end;
        t_coord minor_start;
        logic   minor_neg;
        t_coord minor_mag;
        t_coord major_len;
        t_coord end_x;
        t_coord end_y;
    } t_line_cmd;

endpackage

// ===== rtl/core/dda_line_point_generator.sv =====
// ----------------------------------------------------------------------------
// dda_line_point_generator
// emits every grid point of a line from start to end with a fixed-point dda
// ----------------------------------------------------------------------------
// Each accepted line produces |major delta| + 1 points, start first, end last,
// with last_point set on the end point. The back end loads a line from the
// queue and performs the bit-serial slope division, then emits one point
// per cycle while the output is not stalled. A two-entry queue of
// classified lines lets new lines be accepted while the back end is still
// busy.
module dda_line_point_generator #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_line_valid,
    output logic                 o_line_stall,
    input  dlpg_pkg::t_line_in   i_line,
    output logic                 o_point_valid,
    input  logic                 i_point_stall,
    output dlpg_pkg::t_point_out o_point
);
    import dlpg_pkg::*;

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_empty;
    t_line_cmd front_cmd;
    t_line_cmd head_cmd;

    dlpg_front u_front (
        .i_line_valid (i_line_valid),
        .o_line_stall (o_line_stall),
        .i_line       (i_line),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    dlpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_cmd   (head_cmd)
    );

    dlpg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (queue_empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_point_valid (o_point_valid),
        .i_point_stall (i_point_stall),
        .o_point       (o_point)
    );

endmodule

// ===== rtl/core/dlpg_front.sv =====
// ----------------------------------------------------------------------------
// dlpg_front
// accepts a line and classifies it: major axis, direction, deltas
// ----------------------------------------------------------------------------
module dlpg_front (
    input  logic               i_line_valid,
    output logic               o_line_stall,
    input  dlpg_pkg::t_line_in i_line,
    input  logic               i_queue_full,
    output logic               o_push,
    output dlpg_pkg::t_line_cmd o_cmd
);
    import dlpg_pkg::*;

    t_coord adx;
    t_coord ady;
    logic   x_back;
    logic   y_back;
    logic   maj_x;

    always_comb begin
        x_back = i_line.end_x < i_line.start_x;
        y_back = i_line.end_y < i_line.start_y;
        adx    = x_back ? t_coord'(i_line.start_x - i_line.end_x)
                        : t_coord'(i_line.end_x - i_line.start_x);
        ady    = y_back ? t_coord'(i_line.start_y - i_line.end_y)
                        : t_coord'(i_line.end_y - i_line.start_y);
        maj_x  = adx > ady;

        o_cmd.major_is_x    = maj_x;
        o_cmd.step_backward = maj_x ? x_back : y_back;
        o_cmd.major_start   = maj_x ? i_line.start_x : i_line.start_y;
        o_cmd.major_end     = maj_x ? i_line.end_x : i_line.end_y;
        o_cmd.minor_start   = maj_x ? i_line.start_y : i_line.start_x;
        o_cmd.minor_neg     = maj_x ? y_back : x_back;
        o_cmd.minor_mag     = maj_x ? ady : adx;
        o_cmd.major_len     = maj_x ? adx : ady;
        o_cmd.end_x         = i_line.end_x;
        o_cmd.end_y         = i_line.end_y;
    end

    assign o_line_stall = i_queue_full;
    assign o_push       = i_line_valid && !i_queue_full;

endmodule

// ===== rtl/core/dlpg_queue.sv =====
// ----------------------------------------------------------------------------
// dlpg_queue
// short queue of classified lines between the front and the back
// ----------------------------------------------------------------------------
module dlpg_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dlpg_pkg::t_line_cmd i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output dlpg_pkg::t_line_cmd o_cmd
);
    import dlpg_pkg::*;

    localparam int PTR_W = (C_QUEUE_DEPTH > 1) ? $clog2(C_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(C_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(C_QUEUE_DEPTH - 1);

    t_line_cmd        r_mem [C_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(C_QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/dlpg_back.sv =====
// ----------------------------------------------------------------------------
// dlpg_back
// slope division one bit a cycle, then walks the line one point a cycle while the output is not stalled
// ----------------------------------------------------------------------------
module dlpg_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_queue_empty,
    input  dlpg_pkg::t_line_cmd  i_cmd,
    output logic                 o_pop,
    output logic                 o_point_valid,
    input  logic                 i_point_stall,
    output dlpg_pkg::t_point_out o_point
);
    import dlpg_pkg::*;

    localparam int ACC_W = C_COORD_BITS + FRAC_BITS + 2;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_RUN} t_state;

    t_state                    r_state,     n_state;
    t_line_cmd                 r_cmd,       n_cmd;
    t_coord                    r_rem,       n_rem;
    logic [FRAC_BITS:0]        r_quot,      n_quot;
    logic [CNT_W-1:0]          r_cnt,       n_cnt;
    t_coord                    r_major_pos, n_major_pos;
    logic signed [ACC_W-1:0]   r_acc,       n_acc;
    logic                      r_out_valid, n_out_valid;
    t_point_out                r_out,       n_out;

    logic [C_COORD_BITS:0]     rem2;
    logic                      ge;
    logic                      q0;
    logic signed [FRAC_BITS+1:0] slope_s;
    logic signed [ACC_W-1:0]   slope;
    logic signed [ACC_W-1:0]   rsum;
    t_coord                    minor_pt;
    logic                      out_free;

    always_comb begin
        rem2     = {r_rem, 1'b0};
        ge       = (r_cmd.major_len != '0) && (rem2 >= {1'b0, r_cmd.major_len});
        q0       = (i_cmd.major_len != '0) && (i_cmd.minor_mag >= i_cmd.major_len);
        slope_s  = r_cmd.minor_neg ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});
        slope    = {{(ACC_W-FRAC_BITS-2){slope_s[FRAC_BITS+1]}}, slope_s};
        rsum     = r_acc + HALF;
        minor_pt = rsum[ACC_W-1] ? '0 : rsum[FRAC_BITS +: C_COORD_BITS];
        out_free = !r_out_valid || !i_point_stall;

        n_state     = r_state;
        n_cmd       = r_cmd;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_cnt       = r_cnt;
        n_major_pos = r_major_pos;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_point_stall;
        n_out       = r_out;
        o_pop       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_queue_empty) begin
                    o_pop       = 1'b1;
                    n_cmd       = i_cmd;
                    n_quot      = {{FRAC_BITS{1'b0}}, q0};
                    n_rem       = q0 ? t_coord'(i_cmd.minor_mag - i_cmd.major_len)
                                     : i_cmd.minor_mag;
                    n_cnt       = CNT_W'(FRAC_BITS - 1);
                    n_major_pos = i_cmd.major_start;
                    n_acc       = {2'b00, i_cmd.minor_start, {FRAC_BITS{1'b0}}};
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                n_quot = {r_quot[FRAC_BITS-1:0], ge};
                n_rem  = ge ? t_coord'(rem2 - {1'b0, r_cmd.major_len})
                            : rem2[C_COORD_BITS-1:0];
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_major_pos == r_cmd.major_end) begin
                        n_out.point_x    = r_cmd.end_x;
                        n_out.point_y    = r_cmd.end_y;
                        n_out.last_point = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_out.point_x    = r_cmd.major_is_x ? r_major_pos : minor_pt;
                        n_out.point_y    = r_cmd.major_is_x ? minor_pt : r_major_pos;
                        n_out.last_point = 1'b0;
                        n_major_pos      = r_cmd.step_backward ? r_major_pos - 1'b1
                                                               : r_major_pos + 1'b1;
                        n_acc            = r_acc + slope;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cmd       <= n_cmd;
        r_rem       <= n_rem;
        r_quot      <= n_quot;
        r_cnt       <= n_cnt;
        r_major_pos <= n_major_pos;
        r_acc       <= n_acc;
        r_out       <= n_out;
    end

    assign o_point_valid = r_out_valid;
    assign o_point       = r_out;

endmodule
